@@ src/arithmetic_encoder_static_model_assert.svh @@
// assertion macros for the encoder engine module
`ifndef ARITHMETIC_ENCODER_STATIC_MODEL_ASSERT_SVH
`define ARITHMETIC_ENCODER_STATIC_MODEL_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AESM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define AESM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/aesm_pkg.sv @@
package aesm_pkg;

	// command kinds, same codes as the input opcode
	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FINISH = 2'd2
	} kind_t;

	localparam logic [1:0] OPCODE_UNUSED = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO_FREQ = 3'd1;
	localparam logic [2:0] ST_TOTAL     = 3'd2;
	localparam logic [2:0] ST_NO_MODEL  = 3'd3;
	localparam logic [2:0] ST_PEND_OVF  = 3'd4;

	// interval constants
	localparam logic [31:0] TOP_VAL  = 32'hffff_ffff;
	localparam logic [31:0] Q1_VAL   = 32'h4000_0000;
	localparam logic [31:0] HALF_VAL = 32'h8000_0000;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  symbol;
		logic [15:0] frequency;
	} cmd_t;

	typedef struct packed {
		logic        code_bit;
		logic [31:0] follow_count;
		logic        last;
		logic [2:0]  status;
		logic [31:0] message_symbols;
	} result_t;

endpackage

@@ src/aesm_queue.sv @@
module aesm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  aesm_pkg::cmd_t  push_data,
	output logic            full,
	output logic            head_valid,
	output aesm_pkg::cmd_t  head,
	input  logic            pop
);
	import aesm_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = slot_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ src/aesm_div.sv @@
module aesm_div #(
	parameter int TW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [33+TW-1:0]    dividend,
	input  logic [TW-1:0]       divisor,
	output logic                done,
	output logic [32:0]         quotient
);
	localparam int N  = 33 + TW;
	localparam int CW = $clog2(N + 1);

	logic [TW-1:0] rem_q;
	logic [N-1:0]  quo_q;
	logic [TW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [TW:0]   trial;
	logic [TW:0]   diff;
	logic          ge;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, quo_q[N-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	assign done     = done_q;
	assign quotient = quo_q[32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
				rem_q  <= '0;
				quo_q  <= dividend;
				den_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[TW-1:0] : trial[TW-1:0];
				quo_q <= {quo_q[N-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ src/aesm_engine.sv @@
`include "arithmetic_encoder_static_model_assert.svh"

module aesm_engine #(
	parameter int MAX_TOTAL = 65535,
	parameter int ALPHABET  = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  aesm_pkg::cmd_t     head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_ready,
	output aesm_pkg::result_t  res
);
	import aesm_pkg::*;

	localparam int TW = $clog2(MAX_TOTAL + 1);
	localparam int AW = $clog2(ALPHABET);
	localparam int SW = ((TW > 16) ? TW : 16) + 1;
	localparam int N  = 33 + TW;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_LOAD   = 12'b0000_0000_0010,
		S_READ   = 12'b0000_0000_0100,
		S_MUL_H  = 12'b0000_0000_1000,
		S_DIV_H  = 12'b0000_0001_0000,
		S_MUL_L  = 12'b0000_0010_0000,
		S_DIV_L  = 12'b0000_0100_0000,
		S_ADJ    = 12'b0000_1000_0000,
		S_SCAN   = 12'b0001_0000_0000,
		S_EMIT   = 12'b0010_0000_0000,
		S_FIN    = 12'b0100_0000_0000,
		S_SINGLE = 12'b1000_0000_0000
	} state_t;

	state_t        state_q;
	cmd_t          cmd_q;

	// model memories
	logic [15:0]   freq_mem [ALPHABET];
	logic [TW-1:0] cum_mem  [ALPHABET];
	logic [ALPHABET-1:0] vld_q;
	logic [15:0]   f_rd_q;
	logic [TW-1:0] c_rd_q;
	logic          v_rd_q;
	logic          mem_we;
	logic [AW-1:0] ra;
	logic [AW-1:0] wa;

	// coder state
	logic [TW-1:0] total_q;
	logic [31:0]   low_q;
	logic [31:0]   high_q;
	logic [31:0]   pend_q;
	logic [31:0]   count_q;

	// working registers
	logic [32:0]   range_q;
	logic [TW-1:0] ch_q;
	logic [TW-1:0] cl_q;
	logic [32:0]   qh_q;
	logic [32:0]   ql_q;
	logic [31:0]   lo0_q;
	logic [31:0]   hi0_q;
	logic [31:0]   w_lo_q;
	logic [31:0]   w_hi_q;
	logic [31:0]   w_pend_q;
	logic [5:0]    w_n_q;
	logic [5:0]    n_tot_q;
	logic [31:0]   fin_lo_q;
	logic [31:0]   fin_hi_q;
	logic [31:0]   fin_pend_q;
	logic [2:0]    sgl_st_q;

	logic          out_valid_q;
	result_t       out_q;

	// combinational helpers
	logic          sym_ok;
	logic [TW-1:0] base;
	logic [SW-1:0] ld_sum;
	logic          ld_over;
	logic [15:0]   f_eff;
	logic [TW-1:0] c_eff;
	logic [SW-1:0] ch_sum;
	logic [N-1:0]  div_a;
	logic          div_start;
	logic          div_done;
	logic [32:0]   div_q;
	logic [33:0]   nh;
	logic [33:0]   nl;
	logic          e1;
	logic          e2;
	logic          e3;
	logic [31:0]   adj_lo;
	logic [31:0]   adj_hi;
	logic [31:0]   nx_lo;
	logic [31:0]   nx_hi;
	logic          slot_free;

	assign pop       = (state_q == S_IDLE) && head_valid;
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign slot_free = !out_valid_q || res_ready;

	// load arithmetic
	always_comb begin
		sym_ok  = {1'b0, cmd_q.symbol} < 9'(ALPHABET);
		base    = (cmd_q.symbol == 8'd0) ? '0 : total_q;
		ld_sum  = SW'(base) + SW'(cmd_q.frequency);
		ld_over = ld_sum > SW'(MAX_TOTAL);
		mem_we  = (state_q == S_LOAD) && sym_ok && !ld_over;
		ra      = head.symbol[AW-1:0];
		wa      = cmd_q.symbol[AW-1:0];
	end

	// entry lookup, invalid entries read as zero
	always_comb begin
		f_eff  = v_rd_q ? f_rd_q : 16'd0;
		c_eff  = v_rd_q ? c_rd_q : '0;
		ch_sum = SW'(c_eff) + SW'(f_eff);
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			freq_mem[wa] <= cmd_q.frequency;
			cum_mem[wa]  <= base;
		end
		f_rd_q <= freq_mem[ra];
		c_rd_q <= cum_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			v_rd_q <= 1'b0;
		end else begin
			v_rd_q <= vld_q[ra];
			if (mem_we) begin
				vld_q[wa] <= 1'b1;
			end
		end
	end

	// scaled bound: range times cumulative count, then divided by total
	assign div_start = (state_q == S_MUL_H) || (state_q == S_MUL_L);
	assign div_a     = N'(range_q) * N'((state_q == S_MUL_H) ? ch_q : cl_q);

	aesm_div #(
		.TW(TW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// new interval bounds
	always_comb begin
		nh = 34'(low_q) + 34'(qh_q) - 34'd1;
		nl = 34'(low_q) + 34'(ql_q);
	end

	// one renormalization step
	always_comb begin
		e1     = !w_hi_q[31];
		e2     = !e1 && w_lo_q[31];
		e3     = !e1 && !e2 && (w_lo_q[31:30] == 2'b01) && (w_hi_q[31:30] == 2'b10);
		adj_lo = w_lo_q;
		adj_hi = w_hi_q;
		if (e2) begin
			adj_lo = w_lo_q - HALF_VAL;
			adj_hi = w_hi_q - HALF_VAL;
		end else if (e3) begin
			adj_lo = w_lo_q - Q1_VAL;
			adj_hi = w_hi_q - Q1_VAL;
		end
		nx_lo = {adj_lo[30:0], 1'b0};
		nx_hi = {adj_hi[30:0], 1'b1};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			total_q     <= '0;
			low_q       <= '0;
			high_q      <= TOP_VAL;
			pend_q      <= '0;
			count_q     <= '0;
			range_q     <= '0;
			ch_q        <= '0;
			cl_q        <= '0;
			qh_q        <= '0;
			ql_q        <= '0;
			lo0_q       <= '0;
			hi0_q       <= '0;
			w_lo_q      <= '0;
			w_hi_q      <= '0;
			w_pend_q    <= '0;
			w_n_q       <= '0;
			n_tot_q     <= '0;
			fin_lo_q    <= '0;
			fin_hi_q    <= '0;
			fin_pend_q  <= '0;
			sgl_st_q    <= ST_OK;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						cmd_q <= head;
						case (head.kind)
							KIND_LOAD:   state_q <= S_LOAD;
							KIND_ENCODE: state_q <= S_READ;
							KIND_FINISH: state_q <= S_FIN;
							default:     state_q <= S_IDLE;
						endcase
					end
				end
				S_LOAD: begin
					if (!sym_ok) begin
						sgl_st_q <= ST_ZERO_FREQ;
					end else if (ld_over) begin
						sgl_st_q <= ST_TOTAL;
					end else begin
						total_q  <= ld_sum[TW-1:0];
						sgl_st_q <= ST_OK;
					end
					state_q <= S_SINGLE;
				end
				S_READ: begin
					if (total_q == '0) begin
						sgl_st_q <= ST_NO_MODEL;
						state_q  <= S_SINGLE;
					end else if (!sym_ok || f_eff == 16'd0) begin
						sgl_st_q <= ST_ZERO_FREQ;
						state_q  <= S_SINGLE;
					end else if (ch_sum > SW'(total_q)) begin
						sgl_st_q <= ST_NO_MODEL;
						state_q  <= S_SINGLE;
					end else begin
						ch_q    <= ch_sum[TW-1:0];
						cl_q    <= c_eff;
						range_q <= {1'b0, high_q} - {1'b0, low_q} + 33'd1;
						state_q <= S_MUL_H;
					end
				end
				S_MUL_H: state_q <= S_DIV_H;
				S_DIV_H: begin
					if (div_done) begin
						qh_q    <= div_q;
						state_q <= S_MUL_L;
					end
				end
				S_MUL_L: state_q <= S_DIV_L;
				S_DIV_L: begin
					if (div_done) begin
						ql_q    <= div_q;
						state_q <= S_ADJ;
					end
				end
				S_ADJ: begin
					if (nl > nh || nh > 34'(TOP_VAL)) begin
						sgl_st_q <= ST_NO_MODEL;
						state_q  <= S_SINGLE;
					end else begin
						lo0_q    <= nl[31:0];
						hi0_q    <= nh[31:0];
						w_lo_q   <= nl[31:0];
						w_hi_q   <= nh[31:0];
						w_pend_q <= pend_q;
						w_n_q    <= '0;
						state_q  <= S_SCAN;
					end
				end
				// dry run: count bits and check the pending count, committing directly if no bit is emitted
				S_SCAN: begin
					if ((e1 || e2) && w_n_q != 6'd32) begin
						w_n_q    <= w_n_q + 6'd1;
						w_pend_q <= '0;
						w_lo_q   <= nx_lo;
						w_hi_q   <= nx_hi;
					end else if (e3 && w_pend_q == TOP_VAL) begin
						sgl_st_q <= ST_PEND_OVF;
						state_q  <= S_SINGLE;
					end else if (e3) begin
						w_pend_q <= w_pend_q + 32'd1;
						w_lo_q   <= nx_lo;
						w_hi_q   <= nx_hi;
					end else if (w_n_q == 6'd0) begin
						low_q   <= w_lo_q;
						high_q  <= w_hi_q;
						pend_q  <= w_pend_q;
						count_q <= count_q + 32'd1;
						state_q <= S_IDLE;
					end else begin
						fin_lo_q   <= w_lo_q;
						fin_hi_q   <= w_hi_q;
						fin_pend_q <= w_pend_q;
						n_tot_q    <= w_n_q;
						w_lo_q     <= lo0_q;
						w_hi_q     <= hi0_q;
						w_pend_q   <= pend_q;
						w_n_q      <= '0;
						state_q    <= S_EMIT;
					end
				end
				// replay, one beat per emitted bit
				S_EMIT: begin
					if (e1 || e2) begin
						if (slot_free) begin
							out_valid_q           <= 1'b1;
							out_q.code_bit        <= e2;
							out_q.follow_count    <= w_pend_q;
							out_q.last            <= w_n_q == n_tot_q - 6'd1;
							out_q.status          <= ST_OK;
							out_q.message_symbols <= '0;
							w_n_q                 <= w_n_q + 6'd1;
							w_pend_q              <= '0;
							w_lo_q                <= nx_lo;
							w_hi_q                <= nx_hi;
							if (w_n_q == n_tot_q - 6'd1) begin
								low_q   <= fin_lo_q;
								high_q  <= fin_hi_q;
								pend_q  <= fin_pend_q;
								count_q <= count_q + 32'd1;
								state_q <= S_IDLE;
							end
						end
					end else if (e3) begin
						w_pend_q <= w_pend_q + 32'd1;
						w_lo_q   <= nx_lo;
						w_hi_q   <= nx_hi;
					end
				end
				S_FIN: begin
					if (count_q == '0) begin
						low_q   <= '0;
						high_q  <= TOP_VAL;
						pend_q  <= '0;
						state_q <= S_IDLE;
					end else if (pend_q == TOP_VAL) begin
						sgl_st_q <= ST_PEND_OVF;
						state_q  <= S_SINGLE;
					end else if (slot_free) begin
						out_valid_q           <= 1'b1;
						out_q.code_bit        <= low_q >= Q1_VAL;
						out_q.follow_count    <= pend_q + 32'd1;
						out_q.last            <= 1'b1;
						out_q.status          <= ST_OK;
						out_q.message_symbols <= count_q;
						low_q                 <= '0;
						high_q                <= TOP_VAL;
						pend_q                <= '0;
						count_q               <= '0;
						state_q               <= S_IDLE;
					end
				end
				S_SINGLE: begin
					if (slot_free) begin
						out_valid_q           <= 1'b1;
						out_q.code_bit        <= 1'b0;
						out_q.follow_count    <= '0;
						out_q.last            <= 1'b1;
						out_q.status          <= sgl_st_q;
						out_q.message_symbols <= '0;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`AESM_ASSERT_IMP(a_emit_range, clk, arst_n, state_q == S_EMIT, w_n_q < n_tot_q && n_tot_q <= 6'd32, "emit index out of range")
	`AESM_ASSERT_IMP(a_scan_cap, clk, arst_n, state_q == S_SCAN, w_n_q <= 6'd32, "bit count above limit")
	`AESM_ASSERT_IMP(a_total_cap, clk, arst_n, 1'b1, total_q <= TW'(MAX_TOTAL), "model total above limit")
	`AESM_ASSERT_NXT(a_div_order, clk, arst_n, state_q == S_DIV_H && div_done, state_q == S_MUL_L, "upper bound not followed by lower")

endmodule

@@ src/arithmetic_encoder_static_model.sv @@
// Byte-wise arithmetic encoder with a static frequency model. Load beats fill the
// model; the user must send them in symbol order, the block does not enforce it.
// Encode beats give one output beat per emitted bit, with its count of following
// complement bits; finish beats flush. tlast marks the last beat of each input item
// that gives output. A bit-serial divider computes both interval bounds of an
// encode. The input queue holds two items, so input is taken while the encoder works.
module arithmetic_encoder_static_model #(
	parameter int MAX_TOTAL = 65535,
	parameter int ALPHABET  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // symbol[7:0], frequency[23:8]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // code_bit[0], follow_count[32:1], message_symbols[64:33]
	output logic [2:0]  m_tuser,   // status[2:0]
	output logic        m_tlast
);
	import aesm_pkg::*;

	logic    q_full;
	logic    q_push;
	logic    q_valid;
	logic    q_pop;
	cmd_t    q_in;
	cmd_t    q_head;
	result_t res;

	// front: classify beats, unused opcode is dropped
	always_comb begin
		q_in.kind      = kind_t'(s_tuser);
		q_in.symbol    = s_tdata[7:0];
		q_in.frequency = s_tdata[23:8];
		s_tready       = !q_full;
		q_push         = s_tvalid && !q_full && (s_tuser != OPCODE_UNUSED);
	end

	aesm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	aesm_engine #(
		.MAX_TOTAL (MAX_TOTAL),
		.ALPHABET  (ALPHABET)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	// result packing
	assign m_tdata = {7'd0, res.message_symbols, res.follow_count, res.code_bit};
	assign m_tuser = res.status;
	assign m_tlast = res.last;

endmodule
